// ===== src/integer_matrix_multiply_defines.svh =====
// ----------------------------------------------------------------------------
// Integer matrix multiply assertion macros
// Shared clocking and reset qualification for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IMM_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("integer_matrix_multiply check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IMM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("integer_matrix_multiply check failed");

`endif

// ===== src/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer matrix multiply package
// Sizes, command codes, sequencer states and shared helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imm_pkg;

	localparam int MAX_DIM       = 16;
	localparam int ELEMENT_WIDTH = 32;
	localparam int DIM_CAP       = (MAX_DIM < 16) ? MAX_DIM : 16;
	localparam int DIM_W         = 4;
	localparam int SIZE_W        = 5;
	localparam int DATA_W        = 32;
	localparam int NARROW_W      = (ELEMENT_WIDTH < DATA_W) ? ELEMENT_WIDTH : DATA_W;
	localparam int ADDR_W        = 2 * DIM_W;
	localparam int DEPTH         = 1 << ADDR_W;

	typedef enum logic [1:0] {
		CMD_WRITE_A = 2'd0,
		CMD_WRITE_B = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ROWS_OF_A  = 2'd0,
		REG_INNER_SIZE = 2'd1,
		REG_COLS_OF_B  = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic valid;
		logic clear;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
	} mac_sts_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] cap;
		cap = SIZE_W'(DIM_CAP);
		return (v < cap) ? v : cap;
	endfunction

	function automatic logic [DATA_W-1:0] narrow_element(input logic [DATA_W-1:0] v);
		return DATA_W'(signed'(v[NARROW_W-1:0]));
	endfunction

endpackage

// ===== src/imm_ram.sv =====
// ----------------------------------------------------------------------------
// Integer matrix multiply element store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imm_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/imm_mac.sv =====
// ----------------------------------------------------------------------------
// Integer matrix multiply MAC unit
// One shared multiplier with a registered product and a 32-bit accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imm_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  imm_pkg::mac_ctl_t         ctl,
	input  logic [imm_pkg::DATA_W-1:0] a_data,
	input  logic [imm_pkg::DATA_W-1:0] b_data,
	output imm_pkg::mac_sts_t         sts,
	output logic [imm_pkg::DATA_W-1:0] acc
);

	logic [imm_pkg::DATA_W-1:0] prod_s2;
	logic                       mul_v_s2;
	logic [imm_pkg::DATA_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s2 <= 1'b0;
		end else begin
			mul_v_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_data * b_data;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign sts.busy = mul_v_s2;
	assign acc      = acc_q;

endmodule

// ===== src/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// Integer matrix multiply
// Stores A and B element by element and computes one product row per command.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transaction carries a command. Writes
// of A or B elements give no result. A compute transaction for a row below
// rows_of_a produces cols_of_b result transactions on the output channel
// (out_valid/out_ready), in column order, with last set on the final column.
// Each column streams inner_size reads through the element stores into one
// shared 32x32 multiplier and accumulator. The input is not ready while a row
// is being computed; it is ready again once the last result has been loaded
// into the output register.
// If the receiver stalls, the output register holds its result and the
// sequencer waits before loading the next column. The size registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while idle, as the block itself does not enforce it. Reset sets every size
// to one and empties the output register; the element stores are not cleared
// and must be written before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "integer_matrix_multiply_defines.svh"

module integer_matrix_multiply (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [imm_pkg::SIZE_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       command,
	input  logic [imm_pkg::DIM_W-1:0]        row_index,
	input  logic [imm_pkg::DIM_W-1:0]        col_index,
	input  logic signed [imm_pkg::DATA_W-1:0] element_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [imm_pkg::DIM_W-1:0]        out_row,
	output logic [imm_pkg::DIM_W-1:0]        out_col,
	output logic signed [imm_pkg::DATA_W-1:0] product_sum,
	output logic                             last
);

	imm_pkg::state_t state_q, state_d;

	logic [imm_pkg::SIZE_W-1:0] rows_q, inner_q, cols_q;
	logic [imm_pkg::SIZE_W-1:0] k_q;
	logic [imm_pkg::DIM_W-1:0]  j_q;
	logic [imm_pkg::DIM_W-1:0]  row_q;
	logic                       rd_v_s1;

	logic                       out_valid_q;
	logic [imm_pkg::DIM_W-1:0]  out_row_q, out_col_q;
	logic [imm_pkg::DATA_W-1:0] out_sum_q;
	logic                       out_last_q;

	logic                       accept, start, issue, emit, last_col;
	logic                       we_a, we_b, row_ok, col_ok_a, col_ok_b, row_ok_b;
	imm_pkg::cmd_t              cmd;
	logic [imm_pkg::DATA_W-1:0] wdata, a_data, b_data, acc;
	logic [imm_pkg::ADDR_W-1:0] waddr, raddr_a, raddr_b;
	imm_pkg::mac_ctl_t          mac_ctl;
	imm_pkg::mac_sts_t          mac_sts;

	assign cmd      = imm_pkg::cmd_t'(command);
	assign accept   = in_valid && in_ready;
	assign row_ok   = {1'b0, row_index} < rows_q;
	assign col_ok_a = {1'b0, col_index} < inner_q;
	assign row_ok_b = {1'b0, row_index} < inner_q;
	assign col_ok_b = {1'b0, col_index} < cols_q;
	assign we_a     = accept && (cmd == imm_pkg::CMD_WRITE_A) && row_ok && col_ok_a;
	assign we_b     = accept && (cmd == imm_pkg::CMD_WRITE_B) && row_ok_b && col_ok_b;
	assign waddr    = {row_index, col_index};
	assign wdata    = imm_pkg::narrow_element(element_value);
	assign raddr_a  = {row_q, k_q[imm_pkg::DIM_W-1:0]};
	assign raddr_b  = {k_q[imm_pkg::DIM_W-1:0], j_q};
	assign last_col = ({1'b0, j_q} + imm_pkg::SIZE_W'(1)) == cols_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		start    = 1'b0;
		issue    = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			imm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (cmd == imm_pkg::CMD_COMPUTE) && row_ok && (cols_q != '0)) begin
					start   = 1'b1;
					state_d = imm_pkg::S_RUN;
				end
			end
			imm_pkg::S_RUN: begin
				if (k_q < inner_q) begin
					issue = 1'b1;
				end else begin
					state_d = imm_pkg::S_DRAIN;
				end
			end
			imm_pkg::S_DRAIN: begin
				if (!rd_v_s1 && !mac_sts.busy) begin
					state_d = imm_pkg::S_EMIT;
				end
			end
			imm_pkg::S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = last_col ? imm_pkg::S_IDLE : imm_pkg::S_RUN;
				end
			end
			default: state_d = imm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imm_pkg::S_IDLE;
			rows_q      <= imm_pkg::SIZE_W'(1);
			inner_q     <= imm_pkg::SIZE_W'(1);
			cols_q      <= imm_pkg::SIZE_W'(1);
			k_q         <= '0;
			j_q         <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (cfg_we) begin
				unique case (imm_pkg::reg_idx_t'(cfg_index))
					imm_pkg::REG_ROWS_OF_A:  rows_q  <= imm_pkg::clamp_size(cfg_data);
					imm_pkg::REG_INNER_SIZE: inner_q <= imm_pkg::clamp_size(cfg_data);
					imm_pkg::REG_COLS_OF_B:  cols_q  <= imm_pkg::clamp_size(cfg_data);
					default: ;
				endcase
			end
			if (start || emit) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + imm_pkg::SIZE_W'(1);
			end
			if (start) begin
				j_q <= '0;
			end else if (emit) begin
				j_q <= j_q + imm_pkg::DIM_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			row_q <= row_index;
		end
		if (emit) begin
			out_row_q  <= row_q;
			out_col_q  <= j_q;
			out_sum_q  <= acc;
			out_last_q <= last_col;
		end
	end

	imm_ram #(
		.DEPTH(imm_pkg::DEPTH),
		.WIDTH(imm_pkg::DATA_W)
	) u_store_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr_a),
		.rdata(a_data)
	);

	imm_ram #(
		.DEPTH(imm_pkg::DEPTH),
		.WIDTH(imm_pkg::DATA_W)
	) u_store_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr_b),
		.rdata(b_data)
	);

	assign mac_ctl.valid = rd_v_s1;
	assign mac_ctl.clear = start || emit;

	imm_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.a_data(a_data),
		.b_data(b_data),
		.sts   (mac_sts),
		.acc   (acc)
	);

	assign out_valid   = out_valid_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign product_sum = out_sum_q;
	assign last        = out_last_q;

	`IMM_ASSERT_NOW(a_emit_drained, state_q == imm_pkg::S_EMIT, !rd_v_s1 && !mac_sts.busy)
	`IMM_ASSERT_NOW(a_last_col, out_valid_q && out_last_q, ({1'b0, out_col_q} + 5'd1) == cols_q)
	`IMM_ASSERT_NEXT(a_issue_bound, issue, k_q <= inner_q)

endmodule

// ===== tb/sv/matrix_product_checker.sv =====
// ----------------------------------------------------------------------------
// Matrix product checker
// Watches the size register port and both channels of the matrix multiplier.
// Keeps its own copy of A, B and the sizes, works out the product row for each
// accepted compute transaction and compares every result transaction with the
// oldest expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_product_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [imm_pkg::SIZE_W-1:0]       cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [1:0]                       command,
	input  logic [imm_pkg::DIM_W-1:0]        row_index,
	input  logic [imm_pkg::DIM_W-1:0]        col_index,
	input  logic [imm_pkg::DATA_W-1:0]       element_value,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [imm_pkg::DIM_W-1:0]        out_row,
	input  logic [imm_pkg::DIM_W-1:0]        out_col,
	input  logic [imm_pkg::DATA_W-1:0]       product_sum,
	input  logic                             last,
	output int                               error_count,
	output int                               pending
);

	import imm_pkg::*;

	typedef struct packed {
		logic [DIM_W-1:0]  row;
		logic [DIM_W-1:0]  col;
		logic [DATA_W-1:0] total;
		logic              final_col;
	} product_t;

	logic [DATA_W-1:0] mat_a [MAX_DIM][MAX_DIM];
	logic [DATA_W-1:0] mat_b [MAX_DIM][MAX_DIM];
	int unsigned       rows_a;
	int unsigned       inner_len;
	int unsigned       cols_b;
	product_t          expected_products[$];
	product_t          oldest;
	int                fail_tally;

	function automatic int unsigned dim_from_reg(input logic [SIZE_W-1:0] v);
		return (v > DIM_CAP) ? DIM_CAP : v;
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, $signed(want), $signed(got));
			fail_tally++;
		end
	endfunction

	function automatic void predict_command(input cmd_t cmd, input logic [DIM_W-1:0] r,
			input logic [DIM_W-1:0] c, input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] acc;
		case (cmd)
			CMD_WRITE_A: begin
				if (r < rows_a && c < inner_len)
					mat_a[r][c] = narrow_element(v);
			end
			CMD_WRITE_B: begin
				if (r < inner_len && c < cols_b)
					mat_b[r][c] = narrow_element(v);
			end
			CMD_COMPUTE: begin
				if (r < rows_a) begin
					for (int j = 0; j < cols_b; j++) begin
						acc = '0;
						for (int k = 0; k < inner_len; k++)
							acc += mat_a[r][k] * mat_b[k][j];
						expected_products.push_back('{row: r, col: DIM_W'(j), total: acc,
							final_col: (j == cols_b - 1)});
					end
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a = 1;
			inner_len = 1;
			cols_b = 1;
			fail_tally = 0;
			expected_products.delete();
			foreach (mat_a[i, j]) begin
				mat_a[i][j] = '0;
				mat_b[i][j] = '0;
			end
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ROWS_OF_A:  rows_a = dim_from_reg(cfg_data);
					REG_INNER_SIZE: inner_len = dim_from_reg(cfg_data);
					REG_COLS_OF_B:  cols_b = dim_from_reg(cfg_data);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_products.size() == 0) begin
					$error("unexpected result transaction: row %0d col %0d sum %0d last %0b",
						out_row, out_col, $signed(product_sum), last);
					fail_tally++;
				end else begin
					oldest = expected_products.pop_front();
					check_field("out_row", DATA_W'(oldest.row), DATA_W'(out_row));
					check_field("out_col", DATA_W'(oldest.col), DATA_W'(out_col));
					check_field("product_sum", oldest.total, product_sum);
					check_field("last", DATA_W'(oldest.final_col), DATA_W'(last));
				end
			end
			if (in_valid && in_ready)
				predict_command(cmd_t'(command), row_index, col_index, element_value);
		end
		error_count <= fail_tally;
		pending <= expected_products.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Integer matrix multiply testbench
// Drives size settings and command transactions into the multiplier: a short
// directed part on the corner values and out-of-range cases, then phases of
// random but well-formed load and compute sequences mixed with noise, under
// varying sender gaps and receiver stalls. The checker gives the failures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import imm_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 400;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [SIZE_W-1:0]   cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          command;
	logic [DIM_W-1:0]    row_index;
	logic [DIM_W-1:0]    col_index;
	logic [DATA_W-1:0]   element_value;
	logic                out_valid;
	logic                out_ready;
	logic [DIM_W-1:0]    out_row;
	logic [DIM_W-1:0]    out_col;
	logic [DATA_W-1:0]   product_sum;
	logic                last;
	int                  error_count;
	int                  pending;

	int                  send_idle_pct;
	int                  recv_stall_pct;
	int unsigned         size_rows;
	int unsigned         size_inner;
	int unsigned         size_cols;
	bit                  a_loaded [MAX_DIM][MAX_DIM];
	bit                  b_loaded [MAX_DIM][MAX_DIM];

	integer_matrix_multiply i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_sum   (product_sum),
		.last          (last)
	);

	matrix_product_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_sum   (product_sum),
		.last          (last),
		.error_count   (error_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v);
		return (v > DIM_CAP) ? DIM_CAP : v;
	endfunction

	function automatic logic [DATA_W-1:0] pick_element();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($urandom_range(0, 16)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit row_operands_loaded(input int unsigned r);
		for (int k = 0; k < size_inner; k++) begin
			if (!a_loaded[r][k])
				return 1'b0;
			for (int j = 0; j < size_cols; j++)
				if (!b_loaded[k][j])
					return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				send_idle_pct = 72;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 72;
			end
			IDLE_BOTH: begin
				send_idle_pct = 18;
				recv_stall_pct = 18;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	task automatic configure(input logic [SIZE_W-1:0] r_raw, input logic [SIZE_W-1:0] i_raw,
			input logic [SIZE_W-1:0] c_raw);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_OF_A;
		cfg_data <= r_raw;
		@(posedge clk);
		cfg_index <= REG_INNER_SIZE;
		cfg_data <= i_raw;
		@(posedge clk);
		cfg_index <= REG_COLS_OF_B;
		cfg_data <= c_raw;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_rows = clamp_dim(r_raw);
		size_inner = clamp_dim(i_raw);
		size_cols = clamp_dim(c_raw);
		foreach (a_loaded[i, j]) begin
			a_loaded[i][j] = 1'b0;
			b_loaded[i][j] = 1'b0;
		end
	endtask

	task automatic send_item(input cmd_t cmd, input logic [DIM_W-1:0] r,
			input logic [DIM_W-1:0] c, input logic [DATA_W-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		row_index <= r;
		col_index <= c;
		element_value <= v;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_WRITE_A && r < size_rows && c < size_inner)
			a_loaded[r][c] = 1'b1;
		if (cmd == CMD_WRITE_B && r < size_inner && c < size_cols)
			b_loaded[r][c] = 1'b1;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_a_row(input int unsigned r);
		for (int k = 0; k < size_inner; k++)
			send_item(CMD_WRITE_A, DIM_W'(r), DIM_W'(k), pick_element());
	endtask

	task automatic send_noise();
		logic [DIM_W-1:0] r;
		logic [DIM_W-1:0] c;
		r = DIM_W'($urandom);
		c = DIM_W'($urandom);
		case ($urandom_range(0, 3))
			0: send_item(CMD_NONE, r, c, $urandom);
			1: send_item(CMD_WRITE_A, r, c, pick_element());
			2: send_item(CMD_WRITE_B, r, c, pick_element());
			default: begin
				if (r >= size_rows || row_operands_loaded(r))
					send_item(CMD_COMPUTE, r, c, $urandom);
				else
					send_item(CMD_NONE, r, c, $urandom);
			end
		endcase
	endtask

	task automatic run_phase(input logic [SIZE_W-1:0] r_raw, input logic [SIZE_W-1:0] i_raw,
			input logic [SIZE_W-1:0] c_raw, input idle_mode_t mode, input int budget);
		int          done;
		int          pick;
		int unsigned r;
		done = 0;
		set_idling(mode);
		configure(r_raw, i_raw, c_raw);
		for (int k = 0; k < size_inner; k++) begin
			for (int j = 0; j < size_cols; j++) begin
				send_item(CMD_WRITE_B, DIM_W'(k), DIM_W'(j), pick_element());
				done++;
			end
		end
		while (done < budget) begin
			pick = $urandom_range(0, 99);
			r = $urandom_range(0, size_rows - 1);
			if (pick < 20) begin
				load_a_row(r);
				done += size_inner;
			end else if (pick < 30) begin
				send_item(CMD_WRITE_A, DIM_W'(r), DIM_W'($urandom_range(0, size_inner - 1)),
					pick_element());
				done++;
			end else if (pick < 40) begin
				send_item(CMD_WRITE_B, DIM_W'($urandom_range(0, size_inner - 1)),
					DIM_W'($urandom_range(0, size_cols - 1)), pick_element());
				done++;
			end else if (pick < 80) begin
				if (!row_operands_loaded(r)) begin
					load_a_row(r);
					done += size_inner;
				end
				send_item(CMD_COMPUTE, DIM_W'(r), DIM_W'($urandom), $urandom);
				done++;
			end else begin
				send_noise();
			end
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS_OF_A;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_NONE;
		row_index = '0;
		col_index = '0;
		element_value = '0;
		size_rows = 1;
		size_inner = 1;
		size_cols = 1;
		set_idling(IDLE_NONE);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sizes left at their reset value of one.
		send_item(CMD_WRITE_A, 4'd0, 4'd0, 32'h8000_0000);
		send_item(CMD_WRITE_B, 4'd0, 4'd0, 32'h8000_0000);
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
		send_item(CMD_WRITE_A, 4'd0, 4'd0, 32'h7fff_ffff);
		send_item(CMD_COMPUTE, 4'd0, 4'd15, 32'hffff_ffff);
		send_item(CMD_WRITE_B, 4'd0, 4'd0, 32'h7fff_ffff);
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
		send_item(CMD_WRITE_A, 4'd0, 4'd0, 32'hffff_ffff);
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
		send_item(CMD_WRITE_A, 4'd1, 4'd0, 32'd7);
		send_item(CMD_WRITE_A, 4'd0, 4'd1, 32'd7);
		send_item(CMD_WRITE_B, 4'd1, 4'd0, 32'd7);
		send_item(CMD_WRITE_B, 4'd0, 4'd15, 32'd7);
		send_item(CMD_WRITE_A, 4'd15, 4'd15, 32'hffff_ffff);
		send_item(CMD_COMPUTE, 4'd1, 4'd0, 32'h0);
		send_item(CMD_COMPUTE, 4'd15, 4'd15, 32'hffff_ffff);
		send_item(CMD_NONE, 4'd15, 4'd15, 32'hffff_ffff);
		send_item(CMD_NONE, 4'd0, 4'd0, 32'h0);
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
		settle();

		// Empty dimensions: no rows, then no inner length, then no columns.
		configure(5'd0, 5'd0, 5'd0);
		send_item(CMD_WRITE_A, 4'd0, 4'd0, 32'd3);
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
		settle();
		configure(5'd1, 5'd0, 5'd2);
		send_item(CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
		settle();
		configure(5'd2, 5'd1, 5'd0);
		send_item(CMD_COMPUTE, 4'd1, 4'd0, 32'h0);
		settle();

		run_phase(5'd2, 5'd3, 5'd2, IDLE_NONE, 30);
		run_phase(5'd4, 5'd4, 5'd4, IDLE_SENDER, 35);
		run_phase(5'd3, 5'd2, 5'd5, IDLE_RECEIVER, 35);
		run_phase(5'd5, 5'd1, 5'd3, IDLE_BOTH, 30);
		run_phase(5'd16, 5'd2, 5'd31, IDLE_RECEIVER, 40);
		run_phase(5'd31, 5'd17, 5'd2, IDLE_SENDER, 40);
		run_phase(5'd1, 5'd1, 5'd1, IDLE_BOTH, 20);
		run_phase(SIZE_W'($urandom_range(1, 6)), SIZE_W'($urandom_range(1, 6)),
			SIZE_W'($urandom_range(1, 6)), IDLE_NONE, 30);

		if (error_count == 0 && pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/imm_pkg.sv
src/imm_ram.sv
src/imm_mac.sv
src/integer_matrix_multiply.sv
tb/sv/matrix_product_checker.sv
tb/sv/tb_top.sv
